// ===== src/oosr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the segment reassembly block.
// No dependencies; compiled first.
package oosr_pkg;

    localparam int OOSR_TABLE_ENTRIES = 64;

    localparam int SEQ_W   = 64;
    localparam int LEN_W   = 16;
    localparam int DELIV_W = 22;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_DUP    = 2'd1,
        ST_BELOW  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DELIVER,
        S_DONE
    } t_state;

    typedef enum logic {
        MODE_LOOKUP,
        MODE_DELIVER
    } t_mode;

    // Token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        t_mode              mode;
        logic [SEQ_W-1:0]   key;
        logic [DELIV_W-1:0] delivered;
        logic               hit;
        logic               free_found;
    } t_pkt;

    // Broadcast write into the cell that claimed itself during the lookup.
    typedef struct packed {
        logic             en;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } t_wr;

endpackage

// ===== src/oosr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for segments in and results out.
// No dependencies.
interface oosr_seg_if;
    logic        valid;
    logic        ready;
    logic [63:0] seq_number;
    logic [15:0] payload_len;

    modport source (output valid, output seq_number, output payload_len, input ready);
    modport sink   (input valid, input seq_number, input payload_len, output ready);
endinterface

interface oosr_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] ack_number;
    logic [21:0] delivered_bytes;
    logic        notify;
    logic [1:0]  status;

    modport source (output valid, output ack_number, output delivered_bytes,
                    output notify, output status, input ready);
    modport sink   (input valid, input ack_number, input delivered_bytes,
                    input notify, input status, output ready);
endinterface

// ===== src/oosr_cell.sv =====
`timescale 1ns / 1ps
// One table entry of the reassembly row, with its registered token stage.
// Depends on oosr_pkg.
module oosr_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  oosr_pkg::t_pkt i_pkt,
    input  oosr_pkg::t_wr  i_wr,
    output oosr_pkg::t_pkt o_pkt
);
    import oosr_pkg::*;

    logic               r_valid;
    logic [SEQ_W-1:0]   r_seq;
    logic [LEN_W-1:0]   r_len;
    logic               r_claim;
    t_pkt               r_pkt;
    t_pkt               n_pkt;
    logic               w_match;
    logic [DELIV_W:0]   w_sum;

    assign w_match = i_pkt.valid && r_valid && (r_seq == i_pkt.key);
    assign w_sum   = {1'b0, i_pkt.delivered} + {{(DELIV_W + 1 - LEN_W){1'b0}}, r_len};

    always_comb begin
        n_pkt = i_pkt;
        if (i_pkt.mode == MODE_LOOKUP) begin
            n_pkt.hit        = i_pkt.hit | w_match;
            n_pkt.free_found = i_pkt.free_found | !r_valid;
        end else if (w_match) begin
            // The base moves past this entry and the chain carries on downstream.
            n_pkt.key = i_pkt.key + {{(SEQ_W - LEN_W){1'b0}}, r_len};
            n_pkt.hit = 1'b1;
            if (w_sum[DELIV_W]) begin
                n_pkt.delivered = {DELIV_W{1'b1}};
            end else begin
                n_pkt.delivered = w_sum[DELIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_claim     <= 1'b0;
            r_pkt.valid <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
            if (i_pkt.valid && i_pkt.mode == MODE_LOOKUP) begin
                // Only the first free cell along the row takes the claim.
                r_claim <= !r_valid && !i_pkt.free_found;
            end
            if (i_wr.en && r_claim) begin
                r_valid <= 1'b1;
            end else if (w_match && i_pkt.mode == MODE_DELIVER) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && r_claim) begin
            r_seq <= i_wr.seq;
            r_len <= i_wr.len;
        end
    end

    assign o_pkt = r_pkt;

endmodule

// ===== src/out_of_order_segment_reassembly.sv =====
`timescale 1ns / 1ps
//  Channel   Dir   Request carries
//  i_seg     in    seq_number[63:0], payload_len[15:0]
//  o_res     out   ack_number[63:0], delivered_bytes[21:0], notify, status[1:0]
//
// A request runs a lookup token down the row of TABLE_ENTRIES cells, then one or more
// delivery passes; passes repeat while the last one released an entry. A segment that
// lies below the base skips both and goes straight to S_DONE. Reset is synchronous and
// empties the table at once. A result waiting on o_res does not block acceptance of the
// next request, but that request holds in S_DONE until o_res is free.
// Depends on oosr_pkg, oosr_if and oosr_cell.
module out_of_order_segment_reassembly #(
    parameter int TABLE_ENTRIES = oosr_pkg::OOSR_TABLE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oosr_seg_if.sink    i_seg,
    oosr_res_if.source  o_res
);
    import oosr_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [SEQ_W-1:0]   r_base;
    logic               r_started;
    logic [SEQ_W-1:0]   r_seq;
    logic [LEN_W-1:0]   r_len;
    t_status            r_status;
    t_pkt               r_launch;
    logic [SEQ_W-1:0]   r_res_ack;
    logic [DELIV_W-1:0] r_res_deliv;
    logic               r_out_valid;
    logic [SEQ_W-1:0]   r_out_ack;
    logic [DELIV_W-1:0] r_out_deliv;
    t_status            r_out_status;

    t_pkt               w_pkt [0:TABLE_ENTRIES];
    t_pkt               w_tail;
    t_wr                w_wr;
    logic               w_in_ready;
    logic               w_accept;
    logic               w_out_free;
    logic [SEQ_W-1:0]   w_eff_base;
    logic               w_below;

    assign w_pkt[0] = r_launch;
    assign w_tail   = w_pkt[TABLE_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            oosr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pkt   (w_pkt[g]),
                .i_wr    (w_wr),
                .o_pkt   (w_pkt[g+1])
            );
        end
    endgenerate

    assign w_eff_base = r_started ? r_base : i_seg.seq_number;
    assign w_below    = i_seg.seq_number < w_eff_base;
    assign w_accept   = i_seg.valid && w_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_below ? S_DONE : S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (w_tail.valid) begin
                    n_state = S_DELIVER;
                end
            end
            S_DELIVER: begin
                if (w_tail.valid && !w_tail.hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_wr.en    = 1'b0;
        w_wr.seq   = r_seq;
        w_wr.len   = r_len;
        unique case (r_state)
            S_IDLE:    w_in_ready = 1'b1;
            S_LOOKUP:  w_wr.en = w_tail.valid && !w_tail.hit && (r_len != '0)
                                 && w_tail.free_found;
            S_DELIVER: w_in_ready = 1'b0;
            S_DONE:    w_in_ready = 1'b0;
            default:   w_in_ready = 1'b0;
        endcase
    end

    assign w_out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_started      <= 1'b0;
            r_base         <= '0;
            r_launch.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_launch.valid <= (r_state == S_IDLE && w_accept && !w_below)
                           || (r_state == S_LOOKUP && w_tail.valid)
                           || (r_state == S_DELIVER && w_tail.valid && w_tail.hit);
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_base    <= w_eff_base;
                        r_started <= 1'b1;
                        r_seq     <= i_seg.seq_number;
                        r_len     <= i_seg.payload_len;
                        if (w_below) begin
                            r_status    <= ST_BELOW;
                            r_res_ack   <= w_eff_base;
                            r_res_deliv <= '0;
                        end else begin
                            r_launch.mode       <= MODE_LOOKUP;
                            r_launch.key        <= i_seg.seq_number;
                            r_launch.delivered  <= '0;
                            r_launch.hit        <= 1'b0;
                            r_launch.free_found <= 1'b0;
                        end
                    end
                end
                S_LOOKUP: begin
                    if (w_tail.valid) begin
                        if (w_tail.hit) begin
                            r_status <= ST_DUP;
                        end else if (r_len != '0 && !w_tail.free_found) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_STORED;
                        end
                        // The write lands at this edge, ahead of the delivery token.
                        r_launch.mode       <= MODE_DELIVER;
                        r_launch.key        <= r_base;
                        r_launch.delivered  <= '0;
                        r_launch.hit        <= 1'b0;
                        r_launch.free_found <= 1'b0;
                    end
                end
                S_DELIVER: begin
                    if (w_tail.valid) begin
                        r_base <= w_tail.key;
                        if (w_tail.hit) begin
                            // An entry earlier in the row may now match the new base.
                            r_launch.mode       <= MODE_DELIVER;
                            r_launch.key        <= w_tail.key;
                            r_launch.delivered  <= w_tail.delivered;
                            r_launch.hit        <= 1'b0;
                            r_launch.free_found <= 1'b0;
                        end else begin
                            r_res_ack   <= w_tail.key;
                            r_res_deliv <= w_tail.delivered;
                        end
                    end
                end
                S_DONE:  ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_ack    <= r_res_ack;
            r_out_deliv  <= r_res_deliv;
            r_out_status <= r_status;
        end
    end

    assign i_seg.ready           = w_in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.ack_number      = r_out_ack;
    assign o_res.delivered_bytes = r_out_deliv;
    assign o_res.notify          = (r_out_deliv != '0);
    assign o_res.status          = r_out_status;

    a_tail_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == S_LOOKUP || r_state == S_DELIVER))
        else $error("Token left the row outside a search pass.");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("Accepted request did not start processing.");

    a_below_no_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_BELOW) |-> (r_out_deliv == '0))
        else $error("Below-base result reports delivered bytes.");

    a_write_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |=> (r_state == S_DELIVER && r_launch.valid))
        else $error("Table write not followed by a delivery pass.");

endmodule
